[rtl/core/lgrs_pkg.sv]
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types and constants of the life row stencil.
// Holds the row width, the rule counts and the result record.
// ----------------------------------------------------------------------------
package lgrs_pkg;

	// Bits in one row beat, and the bits needed to count up to that many.
	localparam int ROW_BITS = 64;
	localparam int WIDTH_BITS = 7;

	// B3/S23: a cell is born with three live neighbors, survives with two or three.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// One result row as it waits in the output queue.
	typedef struct packed {
		logic [ROW_BITS-1:0] next_row_cells;
		logic                frame_end;
	} res_t;

endpackage

[rtl/core/lgrs_cfg_if.sv]
// ----------------------------------------------------------------------------
// lgrs_cfg_if: configuration write channel.
// Carries the active row width on a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lgrs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lgrs_pkg::WIDTH_BITS-1:0]    row_width;

	modport source (output valid, output row_width, input ready);
	modport sink (input valid, input row_width, output ready);
endinterface

[rtl/core/lgrs_row_if.sv]
// ----------------------------------------------------------------------------
// lgrs_row_if: input row channel.
// One beat is one row of the current generation and its last-row flag.
// ----------------------------------------------------------------------------
interface lgrs_row_if;
	logic                             valid;
	logic                             ready;
	logic [lgrs_pkg::ROW_BITS-1:0]    row_cells;
	logic                             last_row;

	modport source (output valid, output row_cells, output last_row, input ready);
	modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

[rtl/core/lgrs_res_if.sv]
// ----------------------------------------------------------------------------
// lgrs_res_if: result row channel.
// One beat is one next-generation row and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface lgrs_res_if;
	logic                             valid;
	logic                             ready;
	logic [lgrs_pkg::ROW_BITS-1:0]    next_row_cells;
	logic                             frame_end;

	modport source (output valid, output next_row_cells, output frame_end, input ready);
	modport sink (input valid, input next_row_cells, input frame_end, output ready);
endinterface

[rtl/core/lgrs_lane.sv]
// ----------------------------------------------------------------------------
// lgrs_lane: life rule for a single cell.
// Counts the eight neighbors of a 3x3 window and applies B3/S23.
// ----------------------------------------------------------------------------
module lgrs_lane (
	input  logic [2:0] up,
	input  logic [2:0] mid,
	input  logic [2:0] down,
	output logic       next_cell
);
	import lgrs_pkg::*;

	logic [3:0] count;

	// Neighbor count: the full rows above and below, the sides of the middle row.
	always_comb begin
		count = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
			+ 4'(down[0]) + 4'(down[1]) + 4'(down[2])
			+ 4'(mid[0]) + 4'(mid[2]);
		next_cell = (count == BIRTH_COUNT) || (mid[1] && (count == SURVIVE_COUNT));
	end

endmodule

[rtl/core/lgrs_row.sv]
// ----------------------------------------------------------------------------
// lgrs_row: one next-generation row from three neighboring rows.
// A lane per column works in parallel; the merge masks unused columns.
// ----------------------------------------------------------------------------
module lgrs_row (
	input  logic [lgrs_pkg::ROW_BITS-1:0] up,
	input  logic [lgrs_pkg::ROW_BITS-1:0] mid,
	input  logic [lgrs_pkg::ROW_BITS-1:0] down,
	input  logic [lgrs_pkg::ROW_BITS-1:0] mask,
	output logic [lgrs_pkg::ROW_BITS-1:0] next_row
);
	import lgrs_pkg::*;

	logic [ROW_BITS+1:0] up_pad;
	logic [ROW_BITS+1:0] mid_pad;
	logic [ROW_BITS+1:0] down_pad;
	logic [ROW_BITS-1:0] lane_out;

	// Columns beyond the width and beyond both edges read as dead.
	assign up_pad   = {1'b0, up & mask, 1'b0};
	assign mid_pad  = {1'b0, mid & mask, 1'b0};
	assign down_pad = {1'b0, down & mask, 1'b0};

	// One lane per column, each seeing columns k-1 to k+1.
	for (genvar k = 0; k < ROW_BITS; k++) begin : g_lane
		lgrs_lane u_lane (
			.up        (up_pad[k+2:k]),
			.mid       (mid_pad[k+2:k]),
			.down      (down_pad[k+2:k]),
			.next_cell (lane_out[k])
		);
	end

	// Merge the lanes and clear unused columns.
	assign next_row = lane_out & mask;

endmodule

[rtl/core/life_generation_row_stencil_top.sv]
// ----------------------------------------------------------------------------
// life_generation_row_stencil_top: one B3/S23 life generation, row by row.
// Keeps two rows, computes results in column lanes and queues them.
// ----------------------------------------------------------------------------
// Usage:
// Rows of a grid enter on row_in top to bottom, one row per beat, with
// last_row set on the bottom row. Each row after the first yields the next
// generation of the row above it on row_out; the bottom row yields two beats,
// the row before it and then itself with frame_end set. A one-row grid gives
// a single beat with frame_end set.
// Results are registered in the queue before they are offered on row_out.
// Throughput: one row per cycle while row_in is ready; both results of a bottom
// row are computed in the same cycle by two 64-lane row units.
// Results wait in a four-entry queue; row_in is ready while at least two
// entries are free, so a stalled receiver holds results and input stops once
// three or more results wait.
// cfg sets the active width (saturated at MAX_WIDTH, reset 64) and is always
// ready; a new width applies to every row beat accepted after it. Reset
// clears the held rows and the queue.
// ----------------------------------------------------------------------------
module life_generation_row_stencil_top #(
	parameter int MAX_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	lgrs_cfg_if.sink           cfg,
	lgrs_row_if.sink           row_in,
	lgrs_res_if.source         row_out
);
	import lgrs_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);
	localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);
	localparam logic [QCNT_BITS-1:0] QROOM = QCNT_BITS'(QDEPTH - 2);

	logic [WIDTH_BITS-1:0] row_width_q;
	logic [WIDTH_BITS-1:0] eff_width;
	logic [ROW_BITS-1:0]   mask;
	logic [ROW_BITS-1:0]   row_above_q;
	logic [ROW_BITS-1:0]   row_middle_q;
	logic [1:0]            rows_held_q;
	logic [ROW_BITS-1:0]   res_inner;
	logic [ROW_BITS-1:0]   res_bottom;
	logic                  in_acc;
	logic                  held;
	logic [1:0]            n_push;
	logic                  pop;
	res_t                  first_res;
	res_t                  queue_q [QDEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;

	// Width register; the write channel never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= WIDTH_BITS'(ROW_BITS);
		end else if (cfg.valid) begin
			row_width_q <= cfg.row_width;
		end
	end

	// Active column mask, with the width saturated at MAX_WIDTH.
	assign eff_width = (row_width_q > MAX_W) ? MAX_W : row_width_q;

	always_comb begin
		for (int k = 0; k < ROW_BITS; k++) begin
			mask[k] = (WIDTH_BITS'(k) < eff_width);
		end
	end

	// Inner result: the held middle row between its neighbors.
	lgrs_row u_row_inner (
		.up       (row_above_q),
		.mid      (row_middle_q),
		.down     (row_in.row_cells),
		.mask     (mask),
		.next_row (res_inner)
	);

	// Bottom result: the incoming row with dead space below it.
	lgrs_row u_row_bottom (
		.up       (row_middle_q),
		.mid      (row_in.row_cells),
		.down     ('0),
		.mask     (mask),
		.next_row (res_bottom)
	);

	// Handshake and the number of results this beat produces.
	assign row_in.ready = (count_q <= QROOM);
	assign in_acc = row_in.valid && row_in.ready;
	assign held = (rows_held_q != 2'd0);
	assign n_push = in_acc ? (2'(held) + 2'(row_in.last_row)) : 2'd0;
	assign pop = row_out.valid && row_out.ready;

	always_comb begin
		if (held) begin
			first_res.next_row_cells = res_inner;
			first_res.frame_end = 1'b0;
		end else begin
			first_res.next_row_cells = res_bottom;
			first_res.frame_end = 1'b1;
		end
	end

	// Row history; a bottom row empties it for the next frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_above_q <= '0;
			row_middle_q <= '0;
			rows_held_q <= 2'd0;
		end else if (in_acc) begin
			if (row_in.last_row) begin
				row_above_q <= '0;
				row_middle_q <= '0;
				rows_held_q <= 2'd0;
			end else begin
				row_above_q <= held ? row_middle_q : '0;
				row_middle_q <= row_in.row_cells;
				rows_held_q <= held ? 2'd2 : 2'd1;
			end
		end
	end

	// Result queue storage; a bottom row with history writes two entries.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= first_res;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_BITS'(1)] <= '{next_row_cells: res_bottom,
				frame_end: 1'b1};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_push);
			rd_ptr_q <= rd_ptr_q + QPTR_BITS'(pop);
			count_q <= count_q + QCNT_BITS'(n_push) - QCNT_BITS'(pop);
		end
	end

	assign row_out.valid = (count_q != '0);
	assign row_out.next_row_cells = queue_q[rd_ptr_q].next_row_cells;
	assign row_out.frame_end = queue_q[rd_ptr_q].frame_end;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QDEPTH))
		else $error("result queue overflow");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		rows_held_q != 2'd3)
		else $error("row history count out of range");

	a_frame_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && row_in.last_row |=> rows_held_q == 2'd0 && row_middle_q == '0)
		else $error("row history not emptied after bottom row");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_BITS'(wr_ptr_q - rd_ptr_q) == QPTR_BITS'(count_q))
		else $error("queue pointers disagree with fill count");
`endif

endmodule

[dv/life_generation_row_stencil_top_tb.sv]
// ----------------------------------------------------------------------------
// life_generation_row_stencil_top_tb: self-checking bench for the life row stencil.
// Feeds grids row by row under random valid and ready gaps and predicts every
// next-generation row from its own copy of the held rows and the width.
// A short directed part covers the grid edges and the width extremes, then
// random frames run under many width settings.
// ----------------------------------------------------------------------------
module life_generation_row_stencil_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lgrs_pkg::*;

	localparam int LANES = 64;
	localparam int TARGET_ROWS = 850;
	localparam int SETTLE_CYCLES = 4;

	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [WIDTH_BITS-1:0] width_t;

	// Predicts the next-generation rows and checks them in order.
	class row_scoreboard;
		row_t   above;
		row_t   middle;
		int     held;
		width_t width;
		res_t   expected_rows[$];
		int     mismatches;
		int     checked;
		int     frames;

		function new();
			above = '0;
			middle = '0;
			held = 0;
			width = width_t'(LANES);
			mismatches = 0;
			checked = 0;
			frames = 0;
		endfunction

		function void set_width(width_t w);
			width = w;
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction

		// Cells outside the row read as dead.
		function int cell_at(row_t r, int col);
			if (col < 0 || col >= ROW_BITS)
				return 0;
			return int'(r[col]);
		endfunction

		// One B3/S23 step for the middle row, masked by the active width.
		function row_t step_row(row_t up, row_t mid, row_t down);
			row_t        mask;
			row_t        res;
			int unsigned w;
			int          n;
			w = width;
			if (w > LANES)
				w = LANES;
			mask = (w >= ROW_BITS) ? '1 : ((row_t'(1) << w) - row_t'(1));
			up &= mask;
			mid &= mask;
			down &= mask;
			res = '0;
			for (int c = 0; c < ROW_BITS; c++) begin
				n = 0;
				for (int d = -1; d <= 1; d++) begin
					n += cell_at(up, c + d) + cell_at(down, c + d);
					if (d != 0)
						n += cell_at(mid, c + d);
				end
				if (n == BIRTH_COUNT || (mid[c] && n == SURVIVE_COUNT))
					res[c] = 1'b1;
			end
			return res & mask;
		endfunction

		function void push_row(row_t cells, logic fe);
			res_t r;
			r.next_row_cells = cells;
			r.frame_end = fe;
			expected_rows.push_back(r);
		endfunction

		// An accepted row beat: emit what it completes and shift the held rows.
		function void note_row(row_t cells, logic last);
			if (last)
				frames++;
			if (held == 0) begin
				if (last) begin
					push_row(step_row('0, cells, '0), 1'b1);
				end else begin
					above = '0;
					middle = cells;
					held = 1;
				end
				return;
			end
			push_row(step_row(above, middle, cells), 1'b0);
			if (last) begin
				push_row(step_row(middle, cells, '0), 1'b1);
				above = '0;
				middle = '0;
				held = 0;
			end else begin
				above = middle;
				middle = cells;
				held = 2;
			end
		endfunction

		// An accepted result beat, compared with the oldest expected row.
		function void check_result(row_t cells, logic fe);
			res_t want;
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: cells %h frame_end %b", cells, fe);
				return;
			end
			want = expected_rows.pop_front();
			checked++;
			if (cells !== want.next_row_cells || fe !== want.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected cells %h frame_end %b, got cells %h frame_end %b",
						checked, want.next_row_cells, want.frame_end, cells, fe);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lgrs_cfg_if cfg_bus();
	lgrs_row_if row_bus();
	lgrs_res_if res_bus();

	row_scoreboard sb = new();

	bit sender_idles;
	bit receiver_idles;
	int rows_sent;
	int widths_written;
	int pauses;

	life_generation_row_stencil_top #(
		.MAX_WIDTH(LANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.row_in(row_bus),
		.row_out(res_bus)
	);

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watch both channels; a result beat is checked before a row beat of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready)
				sb.check_result(res_bus.next_row_cells, res_bus.frame_end);
			if (row_bus.valid && row_bus.ready)
				sb.note_row(row_bus.row_cells, row_bus.last_row);
		end
	end

	function automatic int draw_wait(bit enabled);
		return enabled ? $urandom_range(0, 5) : 0;
	endfunction

	// Result receiver: while receiver_idles is set, drops ready for a random stall before each beat.
	initial begin
		int stall;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(receiver_idles);
			if (stall > 0) begin
				@(negedge clk);
				res_bus.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	// Send one row beat after a random gap; valid stays high when the gap is zero.
	task automatic send_row(row_t cells, logic last);
		int gap;
		gap = draw_wait(sender_idles);
		if (gap > 0) begin
			@(negedge clk);
			row_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		row_bus.valid <= 1'b1;
		row_bus.row_cells <= cells;
		row_bus.last_row <= last;
		do @(posedge clk); while (!row_bus.ready);
		rows_sent++;
	endtask

	// Hold off the sender until every expected row is back, then let the block settle.
	task automatic settle_results();
		@(negedge clk);
		row_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(width_t w);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.row_width <= w;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_width(w);
		widths_written++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Random row content with a mix of densities.
	function automatic row_t random_row();
		row_t a;
		row_t b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return a & b;
			4: return a | b;
			default: return a;
		endcase
	endfunction

	function automatic width_t random_width();
		case ($urandom_range(0, 15))
			0: return width_t'(0);
			1, 2: return width_t'(LANES);
			3: return width_t'(1);
			4: return width_t'($urandom_range(LANES + 1, 127));
			5: return width_t'(127);
			default: return width_t'($urandom_range(2, LANES - 1));
		endcase
	endfunction

	// Stimulus: directed grids first, then random frames per width setting.
	initial begin
		int height;
		int pause_at;
		int waited;
		int leftover;
		row_t a;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.row_width = '0;
		row_bus.valid = 1'b0;
		row_bus.row_cells = '0;
		row_bus.last_row = 1'b0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		rows_sent = 0;
		widths_written = 0;
		pauses = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-row grid at the reset width, all cells alive.
		send_row('1, 1'b1);
		// Full grid of live cells, and both edge columns with no wrap.
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1);
		// Blinker and checkerboard.
		send_row('0, 1'b0);
		send_row(64'h0000_0038_0000_0000, 1'b0);
		send_row('0, 1'b1);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_row(64'h5555_5555_5555_5555, 1'b1);

		// Narrowest width, zero width and a width beyond the row.
		settle_results();
		write_width(width_t'(1));
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		settle_results();
		write_width(width_t'(0));
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		settle_results();
		write_width(width_t'(127));
		send_row(random_row(), 1'b1);

		// Width change between the rows of one frame.
		settle_results();
		write_width(width_t'(5));
		send_row('1, 1'b0);
		settle_results();
		write_width(width_t'(3));
		send_row('1, 1'b1);
		settle_results();
		write_width(width_t'(LANES));
		send_row(random_row(), 1'b0);
		send_row(random_row(), 1'b1);

		// Random phases: a width, then a few frames of random height.
		while (rows_sent < TARGET_ROWS) begin
			settle_results();
			sender_idles = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			write_width(random_width());
			repeat ($urandom_range(1, 4)) begin
				height = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
					$urandom_range(1, 8);
				pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, height - 1) : -1;
				for (int r = 0; r < height; r++) begin
					if (r == pause_at) begin
						settle_results();
						pauses++;
					end
					a = random_row();
					send_row(a, r == height - 1);
				end
			end
		end

		// Wait for the last results, with a limit.
		@(negedge clk);
		row_bus.valid <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		leftover = sb.pending();
		if (leftover != 0)
			$display("%0d expected result rows never arrived", leftover);

		$display("Ran %0d rows in %0d frames under %0d width writes, %0d sender pauses.",
			rows_sent, sb.frames, widths_written, pauses);
		$display("Checked %0d result rows, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && leftover == 0) begin
			$display("life_generation_row_stencil_top regression: pass");
		end else begin
			$display("life_generation_row_stencil_top regression: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("timeout waiting on a handshake");
		$display("life_generation_row_stencil_top regression: fail");
		$finish;
	end

endmodule
